@@ sv/bmpd_pkg.sv @@
// Shared types, constants and helpers of the BMP palette decoder.
package bmpd_pkg;

	localparam int MAX_DIM       = 4096;
	localparam int PALETTE_DEPTH = 256;

	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int CNT_W   = $clog2(MAX_DIM);
	localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
	localparam int CC_W    = $clog2(PALETTE_DEPTH + 1);
	localparam int TBL_W   = PAL_AW + 2;
	localparam int HCNT_W  = 6;
	localparam int COORD_W = 12;
	localparam int COLOR_W = 8;
	localparam int RGB_W   = 3 * COLOR_W;

	localparam logic [HCNT_W-1:0] HB_SIGNATURE = HCNT_W'(1);
	localparam logic [HCNT_W-1:0] HB_HDR_SIZE  = HCNT_W'(17);
	localparam logic [HCNT_W-1:0] HB_WIDTH     = HCNT_W'(21);
	localparam logic [HCNT_W-1:0] HB_HEIGHT    = HCNT_W'(25);
	localparam logic [HCNT_W-1:0] HB_PLANES    = HCNT_W'(27);
	localparam logic [HCNT_W-1:0] HB_BPP       = HCNT_W'(29);
	localparam logic [HCNT_W-1:0] HB_COMPRESS  = HCNT_W'(33);
	localparam logic [HCNT_W-1:0] HB_COLORS    = HCNT_W'(49);
	localparam logic [HCNT_W-1:0] HB_LAST      = HCNT_W'(53);

	localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
	localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
	localparam logic [31:0] MAX_BPP       = 32'd8;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_TABLE,
		PH_PIXELS,
		PH_PAD,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		ST_PIXEL,
		ST_HDR_ERR,
		ST_PAD_ERR,
		ST_INDEX_ERR
	} status_t;

	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               last;
		status_t            status;
	} meta_t;

	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr;
		logic [RGB_W-1:0]  data;
	} pal_wr_t;

	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr;
	} pal_rd_t;

	function automatic logic [COORD_W-1:0] to_coord(input logic [DIM_W-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[COORD_W-1:0];
	endfunction

endpackage

@@ sv/bmpd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bmpd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/bmpd_parser.sv @@
// Header checker, color table loader and pixel position tracker.
module bmpd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [7:0]        byte_value,
	input  logic              start_req,
	output bmpd_pkg::pal_wr_t pal_wr,
	output bmpd_pkg::pal_rd_t pal_rd,
	output bmpd_pkg::meta_t   meta
);
	import bmpd_pkg::*;

	phase_t              phase_q, ph, ph_n;
	logic [HCNT_W-1:0]   hcnt_q, hc, hc_n;
	logic [31:0]         fs_q, fs, fs_n, fs_new, cval;
	logic [DIM_W-1:0]    width_q, width_n, height_q, height_n;
	logic [3:0]          bpp_q, bpp_n;
	logic [CC_W-1:0]     cc_q, cc_n;
	logic [TBL_W-1:0]    tcnt_q, tc, tc_n;
	logic [TBL_W:0]      tc_inc;
	logic [CNT_W-1:0]    col_q, col, col_n, frc_q, frc, frc_n;
	logic [DIM_W-1:0]    col_inc, frc_inc, row_val;
	logic [1:0]          pad_q, pad, pad_n;
	logic [COLOR_W-1:0]  blue_q, blue_n, green_q, green_n;
	logic                bad;

	always_comb begin
		ph  = phase_q;
		hc  = hcnt_q;
		fs  = fs_q;
		tc  = tcnt_q;
		col = col_q;
		frc = frc_q;
		pad = pad_q;
		if (start_req) begin
			ph  = PH_HEADER;
			hc  = '0;
			fs  = '0;
			tc  = '0;
			col = '0;
			frc = '0;
			pad = '0;
		end

		ph_n     = ph;
		hc_n     = hc;
		fs_n     = fs;
		width_n  = width_q;
		height_n = height_q;
		bpp_n    = bpp_q;
		cc_n     = cc_q;
		tc_n     = tc;
		col_n    = col;
		frc_n    = frc;
		pad_n    = pad;
		blue_n   = blue_q;
		green_n  = green_q;
		meta     = '0;
		pal_wr   = '0;
		pal_rd   = '0;
		bad      = 1'b0;

		fs_new  = {byte_value, fs[31:8]};
		cval    = (fs_new == 32'd0) ? (32'd1 << bpp_q) : fs_new;
		col_inc = DIM_W'(col) + DIM_W'(1);
		frc_inc = DIM_W'(frc) + DIM_W'(1);
		row_val = height_q - DIM_W'(1) - DIM_W'(frc);
		tc_inc  = (TBL_W + 1)'(tc) + (TBL_W + 1)'(1);

		unique case (ph)
			PH_HEADER: begin
				fs_n = fs_new;
				hc_n = hc + HCNT_W'(1);
				unique case (hc)
					HB_SIGNATURE: bad = fs_new[31:16] != BMP_SIGNATURE;
					HB_HDR_SIZE:  bad = fs_new != INFO_HDR_SIZE;
					HB_WIDTH: begin
						bad = fs_new < 32'd1 || fs_new > 32'(MAX_DIM);
						if (!bad) begin
							width_n = DIM_W'(fs_new);
						end
					end
					HB_HEIGHT: begin
						bad = fs_new < 32'd1 || fs_new > 32'(MAX_DIM);
						if (!bad) begin
							height_n = DIM_W'(fs_new);
						end
					end
					HB_PLANES: bad = fs_new[31:16] != 16'd1;
					HB_BPP: begin
						bad = fs_new[31:16] < 16'd1 || 32'(fs_new[31:16]) > MAX_BPP;
						if (!bad) begin
							bpp_n = fs_new[19:16];
						end
					end
					HB_COMPRESS: bad = fs_new != 32'd0;
					HB_COLORS: begin
						bad = cval > 32'(PALETTE_DEPTH);
						if (!bad) begin
							cc_n = CC_W'(cval);
						end
					end
					HB_LAST: begin
						ph_n = PH_TABLE;
						tc_n = '0;
					end
					default: ;
				endcase
				if (bad) begin
					ph_n        = PH_ERROR;
					meta.valid  = 1'b1;
					meta.status = ST_HDR_ERR;
				end
			end
			PH_TABLE: begin
				unique case (tc[1:0])
					2'd0: blue_n = byte_value;
					2'd1: green_n = byte_value;
					2'd2: begin
						pal_wr.en   = 1'b1;
						pal_wr.addr = tc[TBL_W-1:2];
						pal_wr.data = {byte_value, green_q, blue_q};
					end
					default: ;
				endcase
				tc_n = tc_inc[TBL_W-1:0];
				if (32'(tc_inc) >= (32'(cc_q) << 2)) begin
					ph_n  = PH_PIXELS;
					col_n = '0;
					frc_n = '0;
				end
			end
			PH_PIXELS: begin
				pal_rd.en   = 1'b1;
				pal_rd.addr = byte_value[PAL_AW-1:0];
				meta.valid  = 1'b1;
				meta.column = to_coord(DIM_W'(col));
				meta.row    = to_coord(row_val);
				meta.last   = col_inc == width_q && frc_inc == height_q;
				meta.status = (32'(byte_value) < 32'(cc_q)) ? ST_PIXEL : ST_INDEX_ERR;
				if (col_inc >= width_q) begin
					pad_n = 2'd0 - width_q[1:0];
					col_n = '0;
					if (pad_n != 2'd0) begin
						ph_n = PH_PAD;
					end else begin
						frc_n = CNT_W'(frc_inc);
						ph_n  = (frc_inc >= height_q) ? PH_DONE : PH_PIXELS;
					end
				end else begin
					col_n = CNT_W'(col_inc);
				end
			end
			PH_PAD: begin
				if (byte_value != 8'd0) begin
					meta.valid  = 1'b1;
					meta.row    = to_coord(row_val);
					meta.status = ST_PAD_ERR;
				end
				pad_n = pad - 2'd1;
				if (pad_n == 2'd0) begin
					frc_n = CNT_W'(frc_inc);
					col_n = '0;
					ph_n  = (frc_inc >= height_q) ? PH_DONE : PH_PIXELS;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hcnt_q   <= '0;
			fs_q     <= '0;
			width_q  <= '0;
			height_q <= '0;
			bpp_q    <= '0;
			cc_q     <= '0;
			tcnt_q   <= '0;
			col_q    <= '0;
			frc_q    <= '0;
			pad_q    <= '0;
		end else if (in_fire) begin
			phase_q  <= ph_n;
			hcnt_q   <= hc_n;
			fs_q     <= fs_n;
			width_q  <= width_n;
			height_q <= height_n;
			bpp_q    <= bpp_n;
			cc_q     <= cc_n;
			tcnt_q   <= tc_n;
			col_q    <= col_n;
			frc_q    <= frc_n;
			pad_q    <= pad_n;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			blue_q  <= blue_n;
			green_q <= green_n;
		end
	end

endmodule

@@ sv/bmpd_out.sv @@
// Lookup stage and output register that merge palette data with pixel position.
module bmpd_out (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_fire,
	input  bmpd_pkg::meta_t                meta,
	input  logic [bmpd_pkg::RGB_W-1:0]     rdata,
	output logic                           in_ready,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bmpd_pkg::COLOR_W-1:0]   red,
	output logic [bmpd_pkg::COLOR_W-1:0]   green,
	output logic [bmpd_pkg::COLOR_W-1:0]   blue,
	output logic [bmpd_pkg::COORD_W-1:0]   column,
	output logic [bmpd_pkg::COORD_W-1:0]   row,
	output logic                           last,
	output logic [1:0]                     status
);
	import bmpd_pkg::*;

	meta_t              s1_q, s1_d;
	logic               out_valid_q, out_free;
	logic [RGB_W-1:0]   rgb_q;
	logic [COORD_W-1:0] column_q, row_q;
	logic               last_q;
	status_t            status_q;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !s1_q.valid || out_free;

	always_comb begin
		s1_d       = meta;
		s1_d.valid = in_fire && meta.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_q <= s1_d;
			end
			if (out_free) begin
				out_valid_q <= s1_q.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_q.valid) begin
			rgb_q    <= (s1_q.status == ST_PIXEL) ? rdata : '0;
			column_q <= s1_q.column;
			row_q    <= s1_q.row;
			last_q   <= s1_q.last;
			status_q <= s1_q.status;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = rgb_q[3*COLOR_W-1:2*COLOR_W];
	assign green     = rgb_q[2*COLOR_W-1:COLOR_W];
	assign blue      = rgb_q[COLOR_W-1:0];
	assign column    = column_q;
	assign row       = row_q;
	assign last      = last_q;
	assign status    = status_q;

`ifndef NO_ASSERTIONS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_q.valid && !out_free |=> $stable(s1_q))
		else $error("Lookup stage changed while the output was blocked.");

	a_err_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_PIXEL |-> rgb_q == '0)
		else $error("Error result carries a nonzero color.");

	a_hdr_err_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_HDR_ERR |-> column_q == '0 && row_q == '0 && !last_q)
		else $error("Header error result carries a position.");

	a_pad_err_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_PAD_ERR |-> column_q == '0 && !last_q)
		else $error("Padding result carries a column or a last mark.");
`endif

endmodule

@@ sv/bmp8_palette_decoder.sv @@
// Top level of the byte-serial decoder for 8-bit palettized BMP files.
// The decoder takes one file byte per cycle with no gaps, whatever the phase of the parse,
// as long as results are taken; a result held at the output stalls the input only
// once a second result waits in the lookup stage behind it.
// A result passes through the lookup stage, beside the synchronous palette read,
// and then the output register. The palette memory is never cleared and needs no
// clearing pass; every entry a pixel can select without an index error is loaded
// from the file's color table before the first pixel byte. A start_req byte
// restarts the parse at any time.
module bmp8_palette_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   byte_value,
	input  logic                         start_req,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bmpd_pkg::COLOR_W-1:0] red,
	output logic [bmpd_pkg::COLOR_W-1:0] green,
	output logic [bmpd_pkg::COLOR_W-1:0] blue,
	output logic [bmpd_pkg::COORD_W-1:0] column,
	output logic [bmpd_pkg::COORD_W-1:0] row,
	output logic                         last,
	output logic [1:0]                   status
);
	import bmpd_pkg::*;

	logic             in_fire;
	pal_wr_t          pal_wr;
	pal_rd_t          pal_rd;
	meta_t            meta;
	logic [RGB_W-1:0] rdata;

	assign in_fire = in_valid && in_ready;

	bmpd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.byte_value (byte_value),
		.start_req  (start_req),
		.pal_wr     (pal_wr),
		.pal_rd     (pal_rd),
		.meta       (meta)
	);

	bmpd_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (pal_wr.en && in_fire),
		.waddr (pal_wr.addr),
		.wdata (pal_wr.data),
		.re    (pal_rd.en && in_fire),
		.raddr (pal_rd.addr),
		.rdata (rdata)
	);

	bmpd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.meta      (meta),
		.rdata     (rdata),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.column    (column),
		.row       (row),
		.last      (last),
		.status    (status)
	);

endmodule
